>>> rtl/odq_pkg.sv
package odq_pkg;

  typedef logic signed [31:0] value_t;

  typedef struct packed {
    logic load;
    logic take_left;
    logic take_right;
  } cell_ctrl_t;

  localparam logic [1:0] OP_PUSH_BACK  = 2'd0;
  localparam logic [1:0] OP_PUSH_FRONT = 2'd1;
  localparam logic [1:0] OP_REMOVE     = 2'd2;
  localparam logic [1:0] OP_SEARCH     = 2'd3;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_MISSING = 2'd2;

  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 16;

endpackage

>>> rtl/ordered_deque_remove_by_value_core.sv
// Channel  Direction  Payload
// in_      sink       tdata: opcode[1:0], value[33:2], zero pad to 40 bits
// out_     source     tdata: status[1:0], match_position[5:2], length[10:6], pad to 16
//
// Each transaction steps through accept, per-cell compare against the
// registered value, then apply (shift/load the cell row and write the result).
// The first-match pick is one CAPACITY-wide subtract over the match vector.
// Reset (rst_n low, synchronous) empties the list; cell data is not cleared.
// in_tready stays low while rst_n is low.
// A result held by out_tready low stalls the apply step; once it is handed
// off, the next transaction can be accepted while the new result waits.
module ordered_deque_remove_by_value_core
  import odq_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // opcode[1:0], value[33:2]
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata   // status[1:0], match_position[5:2], length[10:6]
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);

  typedef enum logic [1:0] {S_IDLE, S_CMP, S_APPLY} state_t;

  state_t         state_r;
  logic [1:0]     op_r;
  value_t         value_r;
  logic [CW-1:0]  count_r;
  logic [CW-1:0]  count_nxt;
  logic           out_valid_r;
  logic [1:0]     status_r;
  logic [1:0]     status_nxt;
  logic [3:0]     pos_r;
  logic [4:0]     length_r;

  value_t               cell_data  [CAPACITY];
  logic [CAPACITY-1:0]  cell_match;
  cell_ctrl_t           cell_ctrl  [CAPACITY];

  logic [CAPACITY-1:0]  mv;
  logic [CAPACITY-1:0]  low;
  logic [CAPACITY-1:0]  below;
  logic                 hit_any;
  logic                 full;
  logic                 fire;
  logic [IW-1:0]        hit_pos;

  assign in_tready  = rst_n && (state_r == S_IDLE);
  assign fire       = (state_r == S_APPLY) && (!out_valid_r || out_tready);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W - 11){1'b0}}, length_r, pos_r, status_r};

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    value_t left_d;
    value_t right_d;
    if (g == 0) begin : g_first
      assign left_d = value_r;
    end else begin : g_mid
      assign left_d = cell_data[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right_d = cell_data[g];
    end else begin : g_inner
      assign right_d = cell_data[g+1];
    end

    assign mv[g] = cell_match[g] && (CW'(g) < count_r);

    always_comb begin
      cell_ctrl[g] = '0;
      if (fire) begin
        case (op_r)
          OP_PUSH_BACK:  cell_ctrl[g].load       = !full && (count_r == CW'(g));
          OP_PUSH_FRONT: begin
            cell_ctrl[g].load      = !full && (g == 0);
            cell_ctrl[g].take_left = !full;
          end
          OP_REMOVE:     cell_ctrl[g].take_right = hit_any && !below[g];
          default:       cell_ctrl[g] = '0;
        endcase
      end
    end

    odq_cell u_cell (
      .clk        (clk),
      .value      (value_r),
      .left_data  (left_d),
      .right_data (right_d),
      .ctrl       (cell_ctrl[g]),
      .data       (cell_data[g]),
      .match      (cell_match[g])
    );
  end

  assign hit_any = |mv;
  assign low     = mv & (~mv + 1'b1);
  assign below   = (mv - 1'b1) & ~mv;
  assign full    = (count_r == CW'(CAPACITY));

  always_comb begin
    hit_pos = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (low[i]) begin
        hit_pos = hit_pos | IW'(i);
      end
    end
  end

  always_comb begin
    count_nxt  = count_r;
    status_nxt = ST_DONE;
    case (op_r)
      OP_PUSH_BACK, OP_PUSH_FRONT: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          count_nxt = count_r + 1'b1;
        end
      end
      OP_REMOVE: begin
        if (!hit_any) begin
          status_nxt = ST_MISSING;
        end else begin
          count_nxt = count_r - 1'b1;
        end
      end
      default: begin
        if (!hit_any) begin
          status_nxt = ST_MISSING;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            op_r    <= in_tdata[1:0];
            value_r <= in_tdata[33:2];
            state_r <= S_CMP;
          end
        end
        S_CMP: state_r <= S_APPLY;
        S_APPLY: begin
          if (fire) begin
            count_r     <= count_nxt;
            status_r    <= status_nxt;
            pos_r       <= ((op_r == OP_REMOVE || op_r == OP_SEARCH) && hit_any) ?
                           4'(hit_pos) : 4'd0;
            length_r    <= 5'(count_nxt);
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
      if (out_valid_r && out_tready && !fire) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_cmp_to_apply: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CMP |=> state_r == S_APPLY)
    else $error("compare step not followed by apply");

  a_single_hit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_APPLY |-> $onehot0(low))
    else $error("more than one first match");

  a_full_length: assert property (@(posedge clk) disable iff (!rst_n)
    fire && status_nxt == ST_FULL |=> length_r == 5'(CAPACITY))
    else $error("full status with short list");

endmodule

>>> rtl/odq_cell.sv
module odq_cell
  import odq_pkg::*;
(
  input  logic       clk,
  input  value_t     value,
  input  value_t     left_data,
  input  value_t     right_data,
  input  cell_ctrl_t ctrl,
  output value_t     data,
  output logic       match
);

  value_t data_r;
  value_t data_nxt;
  logic   match_r;

  always_comb begin
    data_nxt = data_r;
    if (ctrl.load) begin
      data_nxt = value;
    end else if (ctrl.take_left) begin
      data_nxt = left_data;
    end else if (ctrl.take_right) begin
      data_nxt = right_data;
    end
  end

  always_ff @(posedge clk) begin
    data_r  <= data_nxt;
    match_r <= (data_r == value);
  end

  assign data  = data_r;
  assign match = match_r;

endmodule
